// ===== rtl/core/rsb_pkg.sv =====
// rsb_pkg: shared constants, codes and controller/datapath types for rgb_scale_and_blend.
// No dependencies; compile first.
`timescale 1ns / 1ps

package rsb_pkg;

    localparam int unsigned STEP_BOUND = 16;

    localparam logic [1:0] CMD_DARKEN  = 2'd0;
    localparam logic [1:0] CMD_LIGHTEN = 2'd1;
    localparam logic [1:0] CMD_MIX     = 2'd2;
    localparam logic [1:0] CMD_SHIFT   = 2'd3;

    localparam logic [1:0] CFG_LIGHTEN_FACTOR = 2'd0;
    localparam logic [1:0] CFG_DARKEN_FACTOR  = 2'd1;
    localparam logic [1:0] CFG_SHIFT_RATE     = 2'd2;
    localparam logic [1:0] CFG_MAX_STEPS      = 2'd3;

    localparam logic [23:0] POW_ONE   = 24'h010000;
    localparam logic [23:0] POW_TWO   = 24'h020000;
    localparam logic [23:0] POW_MAX   = 24'hFFFFFF;
    localparam logic [16:0] W_ONE     = 17'h10000;
    localparam logic [7:0]  COLOR_MAX = 8'hFF;

    typedef struct packed {
        logic       load;
        logic       pow_step;
        logic       div_init;
        logic       div_step;
        logic [2:0] div_bit;
        logic       res_load;
    } t_dp_ctl;

    typedef struct packed {
        logic [7:0] steps;
        logic       pow_stop;
        logic       is_div;
    } t_dp_sts;

endpackage

// ===== rtl/core/rsb_in_if.sv =====
// rsb_in_if: input channel of rgb_scale_and_blend, valid/ready plus one request.
// No dependencies.
`timescale 1ns / 1ps

interface rsb_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [7:0]         main_red;
    logic [7:0]         main_green;
    logic [7:0]         main_blue;
    logic [7:0]         added_red;
    logic [7:0]         added_green;
    logic [7:0]         added_blue;
    logic [7:0]         depth;
    logic signed [18:0] weight;

    modport source (
        output valid, command, main_red, main_green, main_blue,
               added_red, added_green, added_blue, depth, weight,
        input  ready
    );
    modport sink (
        input  valid, command, main_red, main_green, main_blue,
               added_red, added_green, added_blue, depth, weight,
        output ready
    );
endinterface

// ===== rtl/core/rsb_out_if.sv =====
// rsb_out_if: output channel of rgb_scale_and_blend, valid/ready plus one color.
// No dependencies.
`timescale 1ns / 1ps

interface rsb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input  valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== rtl/core/rsb_datapath.sv =====
// rsb_datapath: config registers, power iteration, restoring divider and result register.
// Depends on rsb_pkg; driven by rsb_ctrl through t_dp_ctl.
`timescale 1ns / 1ps

module rsb_datapath
    import rsb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_main_red,
    input  logic [7:0]         i_main_green,
    input  logic [7:0]         i_main_blue,
    input  logic [7:0]         i_added_red,
    input  logic [7:0]         i_added_green,
    input  logic [7:0]         i_added_blue,
    input  logic [7:0]         i_depth,
    input  logic signed [18:0] i_weight,
    input  t_dp_ctl            i_ctl,
    output t_dp_sts            o_sts,
    output logic [7:0]         o_out_red,
    output logic [7:0]         o_out_green,
    output logic [7:0]         o_out_blue
);

    logic [23:0] r_lighten;
    logic [23:0] r_darken;
    logic [15:0] r_shift;
    logic [4:0]  r_max;

    logic [1:0]  r_cmd;
    logic [7:0]  r_main [3];
    logic [7:0]  r_add  [3];
    logic [16:0] r_w;
    logic [7:0]  r_steps;
    logic [23:0] r_fac;
    logic [23:0] r_pow;
    logic [23:0] r_rem  [3];
    logic [7:0]  r_quo  [3];
    logic [2:0]  r_hold;
    logic [7:0]  r_res  [3];

    logic [7:0]  w_in_main [3];
    logic [7:0]  w_in_add  [3];
    logic [7:0]  w_cap;
    logic [7:0]  n_steps;
    logic [23:0] n_fac;
    logic [16:0] n_w;
    logic [47:0] w_prod;
    logic [23:0] n_pow;
    logic [16:0] w_mix_w;
    logic [16:0] w_inv_w;
    logic [31:0] w_div_sub [3];
    logic [7:0]  w_c1      [3];
    logic [31:0] w_lprod   [3];
    logic [24:0] w_msum    [3];
    logic [7:0]  n_res     [3];

    assign w_in_main[0] = i_main_red;
    assign w_in_main[1] = i_main_green;
    assign w_in_main[2] = i_main_blue;
    assign w_in_add[0]  = i_added_red;
    assign w_in_add[1]  = i_added_green;
    assign w_in_add[2]  = i_added_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lighten <= POW_ONE;
            r_darken  <= POW_ONE;
            r_shift   <= 16'd0;
            r_max     <= 5'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LIGHTEN_FACTOR: r_lighten <= i_cfg_data;
                CFG_DARKEN_FACTOR:  r_darken  <= i_cfg_data;
                CFG_SHIFT_RATE:     r_shift   <= i_cfg_data[15:0];
                CFG_MAX_STEPS:      r_max     <= i_cfg_data[4:0];
                default:            r_max     <= r_max;
            endcase
        end
    end

    always_comb begin
        if ({3'b000, r_max} > 8'(STEP_BOUND)) begin
            w_cap = 8'(STEP_BOUND);
        end else begin
            w_cap = {3'b000, r_max};
        end
        case (i_command)
            CMD_DARKEN: begin
                n_steps = (i_depth < w_cap) ? i_depth : w_cap;
                n_fac   = r_darken;
            end
            CMD_LIGHTEN: begin
                n_steps = (i_depth < w_cap) ? i_depth : w_cap;
                n_fac   = r_lighten;
            end
            CMD_SHIFT: begin
                n_steps = i_depth;
                n_fac   = {8'h01, r_shift};
            end
            default: begin
                n_steps = 8'd0;
                n_fac   = POW_ONE;
            end
        endcase
        if (i_weight[18]) begin
            n_w = 17'd0;
        end else if (i_weight[17:0] > {1'b0, W_ONE}) begin
            n_w = W_ONE;
        end else begin
            n_w = i_weight[16:0];
        end
    end

    assign w_prod = r_pow * r_fac;

    always_comb begin
        if (w_prod[47:40] != 8'd0) begin
            n_pow = POW_MAX;
        end else begin
            n_pow = w_prod[39:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_command;
            r_main  <= w_in_main;
            r_add   <= w_in_add;
            r_w     <= n_w;
            r_steps <= n_steps;
            r_fac   <= n_fac;
            r_pow   <= POW_ONE;
        end else if (i_ctl.pow_step) begin
            r_pow <= n_pow;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_div_sub[i] = {8'h00, r_pow} << i_ctl.div_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i_ctl.div_init) begin
                r_rem[i] <= {r_main[i], 16'h0000};
                if (r_main[i] == 8'd0) begin
                    r_quo[i]  <= 8'd0;
                    r_hold[i] <= 1'b1;
                end else if ({8'h00, r_main[i], 8'h00} >= r_pow) begin
                    r_quo[i]  <= COLOR_MAX;
                    r_hold[i] <= 1'b1;
                end else begin
                    r_quo[i]  <= 8'd0;
                    r_hold[i] <= 1'b0;
                end
            end else if (i_ctl.div_step && !r_hold[i]
                         && ({8'h00, r_rem[i]} >= w_div_sub[i])) begin
                r_rem[i]               <= r_rem[i] - w_div_sub[i][23:0];
                r_quo[i][i_ctl.div_bit] <= 1'b1;
            end
        end
    end

    assign w_mix_w = (r_cmd == CMD_SHIFT)
                   ? ((r_pow >= POW_TWO) ? W_ONE : {1'b0, r_pow[15:0]})
                   : r_w;
    assign w_inv_w = W_ONE - w_mix_w;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c1[i]    = (r_main[i] == 8'd0) ? 8'd1 : r_main[i];
            w_lprod[i] = w_c1[i] * r_pow;
            w_msum[i]  = w_inv_w * r_main[i] + w_mix_w * r_add[i];
            case (r_cmd)
                CMD_DARKEN:  n_res[i] = r_quo[i];
                CMD_LIGHTEN: n_res[i] = (w_lprod[i][31:24] != 8'd0)
                                      ? COLOR_MAX : w_lprod[i][23:16];
                default:     n_res[i] = w_msum[i][23:16];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_load) begin
            r_res <= n_res;
        end
    end

    assign o_sts.steps    = r_steps;
    assign o_sts.is_div   = (r_cmd == CMD_DARKEN);
    assign o_sts.pow_stop = (r_cmd == CMD_SHIFT) ? (r_pow >= POW_TWO)
                          : ((r_pow == 24'd0) || (r_pow == POW_MAX));

    assign o_out_red   = r_res[0];
    assign o_out_green = r_res[1];
    assign o_out_blue  = r_res[2];

endmodule

// ===== rtl/core/rsb_ctrl.sv =====
// rsb_ctrl: sequencing state machine and output valid register for rgb_scale_and_blend.
// Depends on rsb_pkg; commands rsb_datapath through t_dp_ctl.
`timescale 1ns / 1ps

module rsb_ctrl
    import rsb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_POWER  = 2'd1;
    localparam logic [1:0] S_DIVIDE = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] r_state, n_state;
    logic [7:0] r_cnt, n_cnt;
    logic [2:0] r_bit, n_bit;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ctl       = '0;
        o_ctl.div_bit = r_bit;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_cnt      = 8'd0;
                    n_state    = S_POWER;
                end
            end
            S_POWER: begin
                if ((r_cnt == i_sts.steps) || i_sts.pow_stop) begin
                    if (i_sts.is_div) begin
                        o_ctl.div_init = 1'b1;
                        n_bit          = 3'd7;
                        n_state        = S_DIVIDE;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    o_ctl.pow_step = 1'b1;
                    n_cnt          = r_cnt + 8'd1;
                end
            end
            S_DIVIDE: begin
                o_ctl.div_step = 1'b1;
                if (r_bit == 3'd0) begin
                    n_state = S_FINISH;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 8'd0;
            r_bit       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/rgb_scale_and_blend.sv =====
// rgb_scale_and_blend: top level joining rsb_ctrl and rsb_datapath to the channels.
// Depends on rsb_pkg, rsb_in_if, rsb_out_if, rsb_ctrl and rsb_datapath.
//
// One request on i_in (command, main and added color, depth, weight) gives one
// color on o_out. Commands: darken, lighten, mix, shift toward. Config registers
// are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them
// only while no transaction is in flight, which the block does not enforce.
// One request is worked at a time; i_in.ready is high only when the sequencer is
// idle. Power steps per request: lighten and darken take at most min(depth,
// max_steps, 16), shift at most depth (up to 255) and ends early once the weight
// is 1, mix takes none. Darken then runs the bit-serial restoring divider. The
// next request can be taken in the same cycle as a result goes valid. The power
// loop runs one 24x24 multiply per cycle. The result sits in an output register;
// a new request is taken while it waits. If o_out stalls, the next result holds
// in the sequencer until the register frees. Synchronous reset restores register
// defaults and drops any result.
`timescale 1ns / 1ps

module rgb_scale_and_blend
    import rsb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    rsb_in_if.sink      i_in,
    rsb_out_if.source   o_out
);

    t_dp_ctl    w_ctl;
    t_dp_sts    w_sts;
    logic       w_in_valid;
    logic       w_in_ready;
    logic       w_out_valid;
    logic       w_out_ready;
    logic [7:0] w_out_red;
    logic [7:0] w_out_green;
    logic [7:0] w_out_blue;

    assign w_in_valid      = i_in.valid;
    assign i_in.ready      = w_in_ready;
    assign w_out_ready     = o_out.ready;
    assign o_out.valid     = w_out_valid;
    assign o_out.out_red   = w_out_red;
    assign o_out.out_green = w_out_green;
    assign o_out.out_blue  = w_out_blue;

    rsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_in_valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (w_out_ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    rsb_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_in.command),
        .i_main_red    (i_in.main_red),
        .i_main_green  (i_in.main_green),
        .i_main_blue   (i_in.main_blue),
        .i_added_red   (i_in.added_red),
        .i_added_green (i_in.added_green),
        .i_added_blue  (i_in.added_blue),
        .i_depth       (i_in.depth),
        .i_weight      (i_in.weight),
        .i_ctl         (w_ctl),
        .o_sts         (w_sts),
        .o_out_red     (w_out_red),
        .o_out_green   (w_out_green),
        .o_out_blue    (w_out_blue)
    );

endmodule

// ===== rtl/core/rsb_checker.sv =====
// rsb_checker: port-level assertions for rgb_scale_and_blend, attached by bind.
// Depends on the top level's channel nets; no package use.
`timescale 1ns / 1ps

module rsb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_red,
    input logic [7:0] i_out_green,
    input logic [7:0] i_out_blue
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_red) && $stable(i_out_green) && $stable(i_out_blue))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second transaction taken while one is in work");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a transaction in work");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid survived reset");

endmodule

bind rgb_scale_and_blend rsb_checker u_rsb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (w_in_valid),
    .i_in_ready  (w_in_ready),
    .i_out_valid (w_out_valid),
    .i_out_ready (w_out_ready),
    .i_out_red   (w_out_red),
    .i_out_green (w_out_green),
    .i_out_blue  (w_out_blue)
);

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for rgb_scale_and_blend (darken, lighten, mix, shift toward).
// Depends on rsb_pkg, rsb_in_if, rsb_out_if and the rgb_scale_and_blend RTL.
// Clocked driver and monitor around the block, expected colors predicted from the registers.
`timescale 1ns / 1ps

module testbench;
    import rsb_pkg::*;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  main_r;
        logic [7:0]  main_g;
        logic [7:0]  main_b;
        logic [7:0]  add_r;
        logic [7:0]  add_g;
        logic [7:0]  add_b;
        logic [7:0]  depth;
        logic [18:0] weight;
    } color_req_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    rsb_in_if  in_if ();
    rsb_out_if out_if ();

    rgb_scale_and_blend u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    logic [23:0] cfg_lighten   = POW_ONE;
    logic [23:0] cfg_darken    = POW_ONE;
    logic [15:0] cfg_shift     = '0;
    logic [4:0]  cfg_max_steps = 5'd8;

    color_req_t pending_reqs[$];
    rgb_t       expected_colors[$];
    color_req_t next_req;
    color_req_t taken_req;
    rgb_t       got_color;
    rgb_t       want_color;

    int unsigned issued_count = 0;
    int unsigned accept_count = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned reg_settings = 0;
    int unsigned cmd_count[4] = '{0, 0, 0, 0};
    bit          send_gaps    = 1'b1;
    bit          recv_gaps    = 1'b1;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [23:0] scaled_power(input logic [23:0] factor,
                                                 input logic [7:0] depth);
        logic [63:0] p;
        int unsigned cap;
        int unsigned steps;
        int unsigned i;
        cap = (cfg_max_steps > STEP_BOUND) ? STEP_BOUND : cfg_max_steps;
        steps = (depth > cap) ? cap : depth;
        p = 64'(POW_ONE);
        i = 0;
        while (i < steps && p != 0 && p < 64'(POW_MAX)) begin
            p = (p * factor) >> 16;
            if (p > 64'(POW_MAX)) begin
                p = 64'(POW_MAX);
            end
            i++;
        end
        return p[23:0];
    endfunction

    function automatic logic [16:0] shift_weight(input logic [7:0] depth);
        logic [63:0] p;
        logic [63:0] q;
        int unsigned i;
        q = 64'(POW_ONE) + cfg_shift;
        p = 64'(POW_ONE);
        i = 0;
        while (i < depth && p < 64'(POW_TWO)) begin
            p = (p * q) >> 16;
            i++;
        end
        p = p - 64'(POW_ONE);
        if (p > 64'(W_ONE)) begin
            return W_ONE;
        end
        return p[16:0];
    endfunction

    function automatic logic [7:0] darken_level(input logic [7:0] c, input logic [23:0] p);
        logic [63:0] q;
        if (c == 0) begin
            return 8'd0;
        end
        if (p == 0) begin
            return COLOR_MAX;
        end
        q = (64'(c) << 16) / 64'(p);
        return (q > 255) ? COLOR_MAX : q[7:0];
    endfunction

    function automatic logic [7:0] lighten_level(input logic [7:0] c, input logic [23:0] p);
        logic [63:0] r;
        r = (64'((c == 0) ? 8'd1 : c) * p) >> 16;
        return (r > 255) ? COLOR_MAX : r[7:0];
    endfunction

    function automatic logic [7:0] mix_level(input logic [7:0] m, input logic [7:0] a,
                                             input logic [16:0] w);
        logic [63:0] s;
        s = 64'(W_ONE - w) * m + 64'(w) * a;
        return s[23:16];
    endfunction

    function automatic rgb_t predict_color(input color_req_t q);
        logic [7:0]  mainc[3];
        logic [7:0]  addc[3];
        logic [7:0]  res[3];
        logic [23:0] pw;
        logic [16:0] w;
        int          ws;
        mainc = '{q.main_r, q.main_g, q.main_b};
        addc  = '{q.add_r, q.add_g, q.add_b};
        ws = $signed(q.weight);
        if (ws < 0) begin
            w = '0;
        end else if (ws > 65536) begin
            w = W_ONE;
        end else begin
            w = ws[16:0];
        end
        pw = '0;
        case (q.cmd)
            CMD_DARKEN:  pw = scaled_power(cfg_darken, q.depth);
            CMD_LIGHTEN: pw = scaled_power(cfg_lighten, q.depth);
            CMD_SHIFT:   w = shift_weight(q.depth);
            default: ;
        endcase
        for (int i = 0; i < 3; i++) begin
            case (q.cmd)
                CMD_DARKEN:  res[i] = darken_level(mainc[i], pw);
                CMD_LIGHTEN: res[i] = lighten_level(mainc[i], pw);
                default:     res[i] = mix_level(mainc[i], addc[i], w);
            endcase
        end
        return '{res[0], res[1], res[2]};
    endfunction

    function automatic color_req_t make_req(input logic [1:0] cmd,
                                            input logic [7:0] mr, mg, mb, ar, ag, ab,
                                            input logic [7:0] depth,
                                            input logic [18:0] weight);
        return '{cmd, mr, mg, mb, ar, ag, ab, depth, weight};
    endfunction

    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return COLOR_MAX;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic color_req_t random_req();
        color_req_t q;
        int unsigned pick;
        q.cmd    = 2'($urandom_range(0, 3));
        q.main_r = random_level();
        q.main_g = random_level();
        q.main_b = random_level();
        q.add_r  = random_level();
        q.add_g  = random_level();
        q.add_b  = random_level();
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            q.depth = 8'($urandom_range(0, 255));
        end else if (q.cmd == CMD_SHIFT) begin
            q.depth = 8'($urandom_range(0, 24));
        end else begin
            q.depth = 8'($urandom_range(0, 20));
        end
        case ($urandom_range(0, 9))
            0:       q.weight = 19'($urandom_range(0, 19'h7FFFF));
            1:       q.weight = (pick < 10) ? 19'h10001 : 19'h7FFFF;
            2:       q.weight = (pick < 10) ? 19'h00000 : 19'h10000;
            default: q.weight = 19'($urandom_range(0, 65536));
        endcase
        return q;
    endfunction

    function automatic logic [23:0] random_factor();
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom_range(24'h008000, 24'h030000));
        endcase
    endfunction

    function automatic logic [15:0] random_rate();
        if ($urandom_range(0, 1) == 0) begin
            return 16'($urandom_range(0, 255));
        end
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_LIGHTEN_FACTOR: cfg_lighten   = data;
            CFG_DARKEN_FACTOR:  cfg_darken    = data;
            CFG_SHIFT_RATE:     cfg_shift     = data[15:0];
            CFG_MAX_STEPS:      cfg_max_steps = data[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [23:0] lf, input logic [23:0] df,
                            input logic [15:0] sr, input logic [4:0] ms);
        write_reg(CFG_LIGHTEN_FACTOR, lf);
        write_reg(CFG_DARKEN_FACTOR, df);
        write_reg(CFG_SHIFT_RATE, 24'(sr));
        write_reg(CFG_MAX_STEPS, 24'(ms));
        reg_settings++;
    endtask

    // hold until every transaction sent has produced its color
    task automatic drain();
        while (pending_reqs.size() != 0 || accept_count != issued_count ||
               expected_colors.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic check_level(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch in %s of color %0d: expected %0d, got %0d",
                         name, results_seen, want, got);
            end
        end
    endtask

    // driver: advance to the next request once the current one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && !(in_if.valid && accept_count != issued_count)) begin
            if (pending_reqs.size() != 0 && !(send_gaps && $urandom_range(0, 99) < 7)) begin
                next_req = pending_reqs.pop_front();
                in_if.command     <= next_req.cmd;
                in_if.main_red    <= next_req.main_r;
                in_if.main_green  <= next_req.main_g;
                in_if.main_blue   <= next_req.main_b;
                in_if.added_red   <= next_req.add_r;
                in_if.added_green <= next_req.add_g;
                in_if.added_blue  <= next_req.add_b;
                in_if.depth       <= next_req.depth;
                in_if.weight      <= next_req.weight;
                in_if.valid       <= 1'b1;
                issued_count++;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= !(recv_gaps && $urandom_range(0, 99) < 7);
    end

    // monitor: check the color leaving, then log the request entering
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got_color = '{out_if.out_red, out_if.out_green, out_if.out_blue};
                if (expected_colors.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected color %0d: %0d %0d %0d", results_seen,
                                 got_color.r, got_color.g, got_color.b);
                    end
                end else begin
                    want_color = expected_colors.pop_front();
                    check_level("red", want_color.r, got_color.r);
                    check_level("green", want_color.g, got_color.g);
                    check_level("blue", want_color.b, got_color.b);
                end
                results_seen++;
            end
            if (in_if.valid && in_if.ready) begin
                taken_req = make_req(in_if.command, in_if.main_red, in_if.main_green,
                                     in_if.main_blue, in_if.added_red, in_if.added_green,
                                     in_if.added_blue, in_if.depth, in_if.weight);
                expected_colors.push_back(predict_color(taken_req));
                cmd_count[taken_req.cmd]++;
                accept_count++;
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        in_if.valid       = 1'b0;
        in_if.command     = CMD_MIX;
        in_if.main_red    = '0;
        in_if.main_green  = '0;
        in_if.main_blue   = '0;
        in_if.added_red   = '0;
        in_if.added_green = '0;
        in_if.added_blue  = '0;
        in_if.depth       = '0;
        in_if.weight      = '0;
        out_if.ready      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // step cap above the bound, darken factor below one
        set_regs(24'h018000, 24'h008000, 16'h1000, 5'd20);
        pending_reqs.push_back(make_req(CMD_DARKEN, 0, 128, 255, 9, 9, 9, 0, 19'h00000));
        pending_reqs.push_back(make_req(CMD_DARKEN, 0, 100, 255, 255, 255, 255, 1, 19'h3FFFF));
        pending_reqs.push_back(make_req(CMD_DARKEN, 1, 2, 3, 0, 0, 0, 255, 19'h40000));
        pending_reqs.push_back(make_req(CMD_LIGHTEN, 0, 1, 255, 0, 0, 0, 3, 19'h00000));
        pending_reqs.push_back(make_req(CMD_LIGHTEN, 0, 10, 200, 255, 255, 255, 255, 19'h7FFFF));
        pending_reqs.push_back(make_req(CMD_MIX, 10, 20, 30, 250, 240, 230, 0, 19'h40000));
        pending_reqs.push_back(make_req(CMD_MIX, 10, 20, 30, 250, 240, 230, 0, 19'h3FFFF));
        pending_reqs.push_back(make_req(CMD_MIX, 10, 20, 30, 250, 240, 230, 0, 19'h00000));
        pending_reqs.push_back(make_req(CMD_MIX, 10, 20, 30, 250, 240, 230, 0, 19'h10000));
        pending_reqs.push_back(make_req(CMD_MIX, 10, 20, 30, 250, 240, 230, 0, 19'h7FFFF));
        pending_reqs.push_back(make_req(CMD_MIX, 10, 20, 30, 250, 240, 230, 0, 19'h10001));
        pending_reqs.push_back(make_req(CMD_MIX, 255, 0, 255, 0, 255, 0, 255, 19'h08000));
        pending_reqs.push_back(make_req(CMD_SHIFT, 10, 20, 30, 250, 240, 230, 0, 19'h08000));
        pending_reqs.push_back(make_req(CMD_SHIFT, 10, 20, 30, 250, 240, 230, 255, 19'h00000));
        pending_reqs.push_back(make_req(CMD_SHIFT, 10, 20, 30, 250, 240, 230, 5, 19'h7FFFF));
        drain();

        // zero factors give a zero power, largest shift rate
        set_regs(24'h000000, 24'h000000, 16'hFFFF, 5'd1);
        pending_reqs.push_back(make_req(CMD_DARKEN, 0, 77, 255, 1, 1, 1, 0, 19'h00000));
        pending_reqs.push_back(make_req(CMD_DARKEN, 0, 77, 255, 1, 1, 1, 5, 19'h00000));
        pending_reqs.push_back(make_req(CMD_LIGHTEN, 0, 77, 255, 1, 1, 1, 3, 19'h00000));
        pending_reqs.push_back(make_req(CMD_SHIFT, 0, 77, 255, 255, 0, 1, 1, 19'h00000));
        pending_reqs.push_back(make_req(CMD_SHIFT, 0, 77, 255, 255, 0, 1, 2, 19'h00000));
        pending_reqs.push_back(make_req(CMD_MIX, 0, 77, 255, 255, 0, 1, 7, 19'h0FFFF));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       set_regs(24'hFFFFFF, 24'h000000, 16'hFFFF, 5'd16);
                1:       set_regs(24'h000000, 24'hFFFFFF, 16'h0000, 5'd0);
                2:       set_regs(24'h018000, 24'h014000, 16'h0800, 5'd8);
                3:       set_regs(random_factor(), random_factor(), random_rate(), 5'd31);
                default: set_regs(random_factor(), random_factor(), random_rate(),
                                  5'($urandom_range(0, 16)));
            endcase
            send_gaps = (ph != 5);
            recv_gaps = (ph != 5);
            for (int n = 0; n < 235; n++) begin
                pending_reqs.push_back(random_req());
            end
            drain();
        end

        repeat (300) @(posedge i_clk);
        $display("requests: %0d darken, %0d lighten, %0d mix, %0d shift over %0d settings",
                 cmd_count[CMD_DARKEN], cmd_count[CMD_LIGHTEN], cmd_count[CMD_MIX],
                 cmd_count[CMD_SHIFT], reg_settings);
        $display("colors checked: %0d, mismatches: %0d, still expected: %0d",
                 results_seen, mismatches, expected_colors.size());
        if (mismatches == 0 && expected_colors.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("timeout with %0d colors still expected", expected_colors.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
